@@ design/fpt_pkg.sv @@
package fpt_pkg;

  localparam int MAX_DEPTH = 6;
  localparam int COORD_W = 10;
  localparam int LEVEL_W = 3;
  localparam int MASK_W = 9;
  localparam int CFG_INDEX_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PATTERN_SIZE = 2'd0,
    CFG_DEPTH        = 2'd1,
    CFG_SEED_MASK    = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] column;
  } in_t;

  typedef struct packed {
    logic filled;
    logic in_range;
  } out_t;

  // Effective configuration as seen by the pipeline.
  typedef struct packed {
    logic               base3;
    logic [LEVEL_W-1:0] depth;
    logic [MASK_W-1:0]  mask;
  } cfg_t;

  // Work item inside the pipeline: remaining quotients of row and column.
  typedef struct packed {
    logic [COORD_W-1:0] row_q;
    logic [COORD_W-1:0] col_q;
    logic               filled;
    logic               in_range;
  } work_t;

  // Image side length for a given base and depth.
  function automatic logic [COORD_W:0] side_of(input logic base3, input logic [LEVEL_W-1:0] d);
    logic [COORD_W:0] side;
    side = (COORD_W+1)'(1);
    for (int k = 0; k < MAX_DEPTH; k++) begin
      if (LEVEL_W'(k) < d) begin
        side = base3 ? (COORD_W+1)'(side * 3) : (COORD_W+1)'(side * 2);
      end
    end
    return side;
  endfunction

  // Divide a 10-bit value by three through a reciprocal multiply.
  // 683 / 2048 overshoots 1/3 by less than 1/6 over this range, so the floor is exact.
  function automatic logic [COORD_W-1:0] div3(input logic [COORD_W-1:0] v);
    logic [2*COORD_W-1:0] prod;
    prod = {{COORD_W{1'b0}}, v} * (2*COORD_W)'(683);
    return {1'b0, prod[2*COORD_W-1:11]};
  endfunction

endpackage

@@ design/fpt_front.sv @@
module fpt_front (
  input  logic          clk,
  input  logic          rst,
  input  fpt_pkg::cfg_t cfg,
  input  logic          up_valid,
  input  fpt_pkg::in_t  up_data,
  input  logic          down_hold,
  output logic          up_hold,
  output logic          valid,
  output fpt_pkg::work_t data
);

  logic [fpt_pkg::COORD_W:0] side;
  logic                      in_range;
  fpt_pkg::work_t            data_next;

  assign up_hold = valid && down_hold;

  always_comb begin
    side = fpt_pkg::side_of(cfg.base3, cfg.depth);
    in_range = ({1'b0, up_data.row} < side) && ({1'b0, up_data.column} < side);
    data_next.row_q = up_data.row;
    data_next.col_q = up_data.column;
    data_next.in_range = in_range;
    // With no levels the only cell is the seed's first entry.
    data_next.filled = in_range && ((cfg.depth != '0) || cfg.mask[0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!up_hold) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_hold) begin
      data <= data_next;
    end
  end

endmodule

@@ design/fpt_digit_stage.sv @@
module fpt_digit_stage (
  input  logic                         clk,
  input  logic                         rst,
  input  fpt_pkg::cfg_t                cfg,
  input  logic [fpt_pkg::LEVEL_W-1:0]  level,
  input  logic                         up_valid,
  input  fpt_pkg::work_t               up_data,
  input  logic                         down_hold,
  output logic                         up_hold,
  output logic                         valid,
  output fpt_pkg::work_t               data
);

  logic [fpt_pkg::COORD_W-1:0] row_q3;
  logic [fpt_pkg::COORD_W-1:0] col_q3;
  logic [1:0]                  row_digit;
  logic [1:0]                  col_digit;
  logic [3:0]                  mask_idx;
  fpt_pkg::work_t              data_next;

  assign up_hold = valid && down_hold;

  always_comb begin
    row_q3 = fpt_pkg::div3(up_data.row_q);
    col_q3 = fpt_pkg::div3(up_data.col_q);
    data_next = up_data;
    if (cfg.base3) begin
      row_digit = 2'(up_data.row_q - fpt_pkg::COORD_W'(row_q3 * 3));
      col_digit = 2'(up_data.col_q - fpt_pkg::COORD_W'(col_q3 * 3));
      data_next.row_q = row_q3;
      data_next.col_q = col_q3;
    end else begin
      row_digit = {1'b0, up_data.row_q[0]};
      col_digit = {1'b0, up_data.col_q[0]};
      data_next.row_q = up_data.row_q >> 1;
      data_next.col_q = up_data.col_q >> 1;
    end
    // The seed mask keeps a row stride of three for both bases.
    mask_idx = 4'(row_digit * 3) + 4'(col_digit);
    if (level < cfg.depth) begin
      data_next.filled = up_data.filled && cfg.mask[mask_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!up_hold) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_hold) begin
      data <= data_next;
    end
  end

endmodule

@@ design/fractal_pattern_pixel_test_core.sv @@
// Fractal pixel test: each transaction on the input carries one (row, column)
// coordinate and yields exactly one result telling whether the pixel lies inside
// the pattern_size**depth image and whether that cell is filled. A new coordinate
// can be taken every clock while in_stall is low. The pipeline is one range-check
// stage followed by one stage per possible recursion level, each peeling off the
// lowest base-2 or base-3 digit of row and column and testing the seed mask. A
// stall on the output only backs up the pipeline as far as it is full, so empty
// stages still take new coordinates. Configuration writes are always accepted
// and must only be issued while no coordinate is in flight.
module fractal_pattern_pixel_test_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  fpt_pkg::in_t                     in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output fpt_pkg::out_t                    out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fpt_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [fpt_pkg::MASK_W-1:0]       cfg_data
);

  localparam int NSTAGE = fpt_pkg::MAX_DEPTH + 1;

  logic [1:0]                  pattern_size;
  logic [fpt_pkg::LEVEL_W-1:0] depth;
  logic [fpt_pkg::MASK_W-1:0]  seed_mask;
  fpt_pkg::cfg_t               cfg;

  logic           stage_valid [NSTAGE];
  fpt_pkg::work_t stage_data  [NSTAGE];
  logic           stage_hold  [NSTAGE];
  logic           all_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_size <= 2'd3;
      depth <= fpt_pkg::LEVEL_W'(1);
      seed_mask <= fpt_pkg::MASK_W'(495);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fpt_pkg::CFG_PATTERN_SIZE: pattern_size <= cfg_data[1:0];
        fpt_pkg::CFG_DEPTH:        depth <= cfg_data[fpt_pkg::LEVEL_W-1:0];
        fpt_pkg::CFG_SEED_MASK:    seed_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.base3 = (pattern_size == 2'd3);
    cfg.depth = (depth > fpt_pkg::LEVEL_W'(fpt_pkg::MAX_DEPTH)) ?
                fpt_pkg::LEVEL_W'(fpt_pkg::MAX_DEPTH) : depth;
    cfg.mask = seed_mask;
  end

  fpt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .up_valid  (in_valid),
    .up_data   (in_data),
    .down_hold (stage_hold[1]),
    .up_hold   (stage_hold[0]),
    .valid     (stage_valid[0]),
    .data      (stage_data[0])
  );

  for (genvar k = 1; k < NSTAGE; k++) begin : g_level
    logic down_hold;
    if (k == NSTAGE - 1) begin : g_last
      assign down_hold = out_stall;
    end else begin : g_mid
      assign down_hold = stage_hold[k+1];
    end
    fpt_digit_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .cfg       (cfg),
      .level     (fpt_pkg::LEVEL_W'(k - 1)),
      .up_valid  (stage_valid[k-1]),
      .up_data   (stage_data[k-1]),
      .down_hold (down_hold),
      .up_hold   (stage_hold[k]),
      .valid     (stage_valid[k]),
      .data      (stage_data[k])
    );
  end

  assign in_stall = stage_hold[0];
  assign out_valid = stage_valid[NSTAGE-1];
  assign out_data.filled = stage_data[NSTAGE-1].filled;
  assign out_data.in_range = stage_data[NSTAGE-1].in_range;

  always_comb begin
    all_full = 1'b1;
    for (int k = 0; k < NSTAGE; k++) begin
      all_full = all_full && stage_valid[k];
    end
  end

  // A transaction is refused only when every stage holds an item.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (all_full && out_stall))
    else $error("input stalled while the pipeline has room");

  a_out_of_range_blank: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.in_range) |-> !out_data.filled)
    else $error("pixel outside the image reported as filled");

  a_depth_zero_seed: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.in_range && cfg.depth == '0) |-> (out_data.filled == seed_mask[0]))
    else $error("single-cell image does not follow the first seed entry");

endmodule
